// ===== rtl/sobel_edge_magnitude_top_defines.svh =====
// ----------------------------------------------------------------------------
// Sobel edge magnitude - assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef SOBEL_EDGE_MAGNITUDE_TOP_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define SEM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define SEM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, checked through reset as well
`define SEM_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sem_pkg.sv =====
// ----------------------------------------------------------------------------
// Sobel edge magnitude - package
// Payload types, geometry limits and arithmetic constants.
// ----------------------------------------------------------------------------
package sem_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int DIM_W      = 12;
  localparam int COORD_W    = 11;
  localparam int STORE_AW   = $clog2(MAX_WIDTH);
  localparam int PIX_W      = 8;

  // register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MODE   = 2'd2;

  // luma weights, sum scaled by 1000
  localparam int GRAY_R     = 299;
  localparam int GRAY_G     = 587;
  localparam int GRAY_B     = 114;
  localparam int GRAY_DIV   = 1000;
  localparam int RECIP_SH   = 20;
  localparam int GRAY_RECIP = (1 << RECIP_SH) / GRAY_DIV;
  localparam int SUM_W      = 18;

  // gradient and magnitude widths
  localparam int GRAD_W     = 11;
  localparam int SQ_W       = 21;
  localparam int ROOT_IN_W  = 16;
  localparam int ROOT_W     = 8;

  typedef struct packed {
    logic [PIX_W-1:0] first_channel;
    logic [PIX_W-1:0] second_channel;
    logic [PIX_W-1:0] third_channel;
  } pixel_t;

  typedef struct packed {
    logic [COORD_W-1:0] center_column;
    logic [COORD_W-1:0] center_row;
    logic [PIX_W-1:0]   edge_magnitude;
    logic               frame_done;
  } result_t;

endpackage

// ===== rtl/sem_ram.sv =====
// ----------------------------------------------------------------------------
// Sobel edge magnitude - line store RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sem_ram #(
  parameter int DATA_W = 16,
  parameter int ADDR_W = 11
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/sem_isqrt.sv =====
// ----------------------------------------------------------------------------
// Sobel edge magnitude - integer square root
// Digit-by-digit floor square root of a 16-bit value, one result bit a cycle.
// ----------------------------------------------------------------------------
module sem_isqrt (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [sem_pkg::ROOT_IN_W-1:0]  operand,
  output logic                           done,
  output logic [sem_pkg::ROOT_W-1:0]     root
);
  import sem_pkg::*;

  localparam int RES_W = ROOT_IN_W + 1;
  localparam int PRB_W = ROOT_IN_W - 1;

  logic               busy;
  logic [ROOT_IN_W-1:0] rem;
  logic [RES_W-1:0]   res;
  logic [PRB_W-1:0]   probe;
  logic [RES_W-1:0]   trial;

  assign trial = res + RES_W'(probe);
  assign root  = res[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && probe == PRB_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= operand;
      res   <= '0;
      probe <= {1'b1, {(PRB_W-1){1'b0}}};
    end else if (busy) begin
      probe <= probe >> 2;
      if (RES_W'(rem) >= trial) begin
        rem <= rem - trial[ROOT_IN_W-1:0];
        res <= (res >> 1) + RES_W'(probe);
      end else begin
        res <= res >> 1;
      end
    end
  end

endmodule

// ===== rtl/sobel_edge_magnitude_top.sv =====
// ----------------------------------------------------------------------------
// Sobel edge magnitude - top level
// 3x3 Sobel gradient magnitude over a raster pixel stream, interior only.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                payload
//  pixel     in   pixel_valid/pixel_ready  sem_pkg::pixel_t (r or gray, g, b)
//  result    out  result_valid/result_ready sem_pkg::result_t (col, row, mag)
//  cfg       in   cfg_valid/cfg_ready      cfg_index (2b), cfg_data (12b)
//
//  One request is worked at a time. Every pixel runs the three-step gray
//  conversion and the window update; an interior pixel then adds gradient,
//  square and the 8-step square root, skipped when the gradient saturates.
//  Reset (rst, synchronous) returns positions, window and registers to their
//  defaults; line store contents are left as they are.
//  A stalled result holds in the output register while the next pixel enters.
//  Register writes are taken only between requests; pixel_ready drops while
//  a write is offered.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        pixel_valid,
  output logic                        pixel_ready,
  input  sem_pkg::pixel_t             pixel,
  output logic                        result_valid,
  input  logic                        result_ready,
  output sem_pkg::result_t            result,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [sem_pkg::DIM_W-1:0]   cfg_data
);
  import sem_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SUM  = 4'd1;
  localparam logic [3:0] ST_DIV  = 4'd2;
  localparam logic [3:0] ST_FIX  = 4'd3;
  localparam logic [3:0] ST_WIN  = 4'd4;
  localparam logic [3:0] ST_GRAD = 4'd5;
  localparam logic [3:0] ST_SQ   = 4'd6;
  localparam logic [3:0] ST_ROOT = 4'd7;
  localparam logic [3:0] ST_WAIT = 4'd8;
  localparam logic [3:0] ST_OUT  = 4'd9;

  localparam int LINE_W = 2 * PIX_W;

  // configuration
  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic             color_mode;
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;

  // raster position of the next incoming pixel
  logic [COORD_W-1:0] col_pos;
  logic [COORD_W-1:0] row_pos;

  logic [3:0] state;
  logic       accept;

  // per-request latches
  logic [PIX_W-1:0]    r_ch, g_ch, b_ch;
  logic                mode_q;
  logic [STORE_AW-1:0] item_addr;
  logic                emit;
  logic                last;
  logic [COORD_W-1:0]  out_col;
  logic [COORD_W-1:0]  out_row;

  // gray conversion
  logic [SUM_W-1:0]  pix_sum;
  logic [PIX_W-1:0]  quot_est;
  logic [PIX_W-1:0]  gray;
  logic [SUM_W+10:0] div_prod;
  logic [SUM_W-1:0]  div_rem;
  logic [PIX_W-1:0]  gray_fix;

  // line store: {older row, newer row} per column
  logic              ram_rd_en;
  logic              ram_wr_en;
  logic [LINE_W-1:0] ram_rdata;
  logic [LINE_W-1:0] ram_wdata;

  // window, row index first; column 2 is the newest
  logic [PIX_W-1:0] win [3][3];

  logic [PIX_W+1:0]         gx_pos, gx_neg, gy_pos, gy_neg;
  logic signed [GRAD_W-1:0] gx, gy;
  logic signed [2*GRAD_W-1:0] gx_sq, gy_sq;
  logic [SQ_W-1:0]          sq;
  logic [PIX_W-1:0]         mag;

  logic                     root_start;
  logic                     root_done;
  logic [ROOT_W-1:0]        root_val;

  // clamp geometry: zero acts as one, above the store acts as the maximum
  assign w_eff = (image_width == '0) ? DIM_W'(1) :
                 (image_width > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : image_width;
  assign h_eff = (image_height == '0) ? DIM_W'(1) :
                 (image_height > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : image_height;

  // writes only between requests; a pending write holds off the next pixel
  assign cfg_ready   = (state == ST_IDLE);
  assign pixel_ready = (state == ST_IDLE) && !cfg_valid;
  assign accept      = pixel_valid && pixel_ready;

  // configuration registers; a geometry write restarts the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_W'(640);
      image_height <= DIM_W'(480);
      color_mode   <= 1'b0;
      col_pos      <= '0;
      row_pos      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WIDTH: begin
          image_width <= cfg_data;
          col_pos     <= '0;
          row_pos     <= '0;
        end
        REG_HEIGHT: begin
          image_height <= cfg_data;
          col_pos      <= '0;
          row_pos      <= '0;
        end
        REG_MODE: begin
          color_mode <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      // raster advance with wrap at the frame end
      if (DIM_W'(col_pos) + DIM_W'(1) >= w_eff) begin
        col_pos <= '0;
        row_pos <= (DIM_W'(row_pos) + DIM_W'(1) >= h_eff) ? '0 : row_pos + COORD_W'(1);
      end else begin
        col_pos <= col_pos + COORD_W'(1);
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: if (accept) state <= ST_SUM;
        ST_SUM:  state <= ST_DIV;
        ST_DIV:  state <= ST_FIX;
        ST_FIX:  state <= ST_WIN;
        ST_WIN:  state <= emit ? ST_GRAD : ST_IDLE;
        ST_GRAD: state <= ST_SQ;
        ST_SQ:   state <= ST_ROOT;
        ST_ROOT: state <= (sq[SQ_W-1:ROOT_IN_W] != '0) ? ST_OUT : ST_WAIT;
        ST_WAIT: if (root_done) state <= ST_OUT;
        ST_OUT:  if (!result_valid || result_ready) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // request latch: channels, and the output decision made on the old position
  always_ff @(posedge clk) begin
    if (accept) begin
      r_ch      <= pixel.first_channel;
      g_ch      <= pixel.second_channel;
      b_ch      <= pixel.third_channel;
      mode_q    <= color_mode;
      item_addr <= col_pos[STORE_AW-1:0];
      emit      <= (w_eff >= DIM_W'(3)) && (h_eff >= DIM_W'(3)) &&
                   (col_pos >= COORD_W'(2)) && (row_pos >= COORD_W'(2));
      last      <= (DIM_W'(col_pos) == w_eff - DIM_W'(1)) &&
                   (DIM_W'(row_pos) == h_eff - DIM_W'(1));
      out_col   <= col_pos - COORD_W'(1);
      out_row   <= row_pos - COORD_W'(1);
    end
  end

  // gray = floor(weighted sum / 1000): reciprocal estimate, one correction
  assign div_prod = (SUM_W+11)'(pix_sum) * (SUM_W+11)'(GRAY_RECIP);
  assign div_rem  = pix_sum - SUM_W'(SUM_W'(quot_est) * SUM_W'(GRAY_DIV));
  assign gray_fix = quot_est + PIX_W'(div_rem >= SUM_W'(GRAY_DIV));

  always_ff @(posedge clk) begin
    case (state)
      ST_SUM: begin
        pix_sum <= SUM_W'(r_ch) * SUM_W'(GRAY_R) + SUM_W'(g_ch) * SUM_W'(GRAY_G) +
                   SUM_W'(b_ch) * SUM_W'(GRAY_B);
      end
      ST_DIV: begin
        quot_est <= div_prod[RECIP_SH+PIX_W-1:RECIP_SH];
      end
      ST_FIX: begin
        gray <= mode_q ? gray_fix : r_ch;
      end
      default: begin
      end
    endcase
  end

  // line store: read at accept, data held until the write-back in ST_WIN
  assign ram_rd_en = accept;
  assign ram_wr_en = (state == ST_WIN);
  assign ram_wdata = {ram_rdata[PIX_W-1:0], gray};

  sem_ram #(
    .DATA_W (LINE_W),
    .ADDR_W (STORE_AW)
  ) u_line (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (item_addr),
    .wr_data (ram_wdata),
    .rd_en   (ram_rd_en),
    .rd_addr (col_pos[STORE_AW-1:0]),
    .rd_data (ram_rdata)
  );

  // window shift
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win[i][j] <= '0;
        end
      end
    end else if (state == ST_WIN) begin
      for (int i = 0; i < 3; i++) begin
        win[i][0] <= win[i][1];
        win[i][1] <= win[i][2];
      end
      win[0][2] <= ram_rdata[LINE_W-1:PIX_W];
      win[1][2] <= ram_rdata[PIX_W-1:0];
      win[2][2] <= gray;
    end
  end

  // Sobel kernels
  assign gx_pos = (PIX_W+2)'(win[0][2]) + {1'b0, win[1][2], 1'b0} + (PIX_W+2)'(win[2][2]);
  assign gx_neg = (PIX_W+2)'(win[0][0]) + {1'b0, win[1][0], 1'b0} + (PIX_W+2)'(win[2][0]);
  assign gy_pos = (PIX_W+2)'(win[2][0]) + {1'b0, win[2][1], 1'b0} + (PIX_W+2)'(win[2][2]);
  assign gy_neg = (PIX_W+2)'(win[0][0]) + {1'b0, win[0][1], 1'b0} + (PIX_W+2)'(win[0][2]);

  assign gx_sq = gx * gx;
  assign gy_sq = gy * gy;

  always_ff @(posedge clk) begin
    if (state == ST_GRAD) begin
      gx <= $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
      gy <= $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
    end
    if (state == ST_SQ) begin
      sq <= SQ_W'(gx_sq[SQ_W-2:0]) + SQ_W'(gy_sq[SQ_W-2:0]);
    end
  end

  // magnitude: saturate when the square exceeds 16 bits, else floor root
  assign root_start = (state == ST_ROOT) && (sq[SQ_W-1:ROOT_IN_W] == '0);

  sem_isqrt u_root (
    .clk     (clk),
    .rst     (rst),
    .start   (root_start),
    .operand (sq[ROOT_IN_W-1:0]),
    .done    (root_done),
    .root    (root_val)
  );

  always_ff @(posedge clk) begin
    if (state == ST_ROOT) begin
      mag <= '1;
    end else if (state == ST_WAIT && root_done) begin
      mag <= root_val;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_OUT && (!result_valid || result_ready)) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!result_valid || result_ready)) begin
      result.center_column  <= out_col;
      result.center_row     <= out_row;
      result.edge_magnitude <= mag;
      result.frame_done     <= last;
    end
  end

endmodule

// ===== rtl/sem_checker.sv =====
// ----------------------------------------------------------------------------
// Sobel edge magnitude - port checker
// Watches the top level ports; attached by bind.
// ----------------------------------------------------------------------------
`include "sobel_edge_magnitude_top_defines.svh"

module sem_checker (
  input logic             clk,
  input logic             rst,
  input logic             pixel_valid,
  input logic             pixel_ready,
  input logic             result_valid,
  input logic             result_ready,
  input sem_pkg::result_t result
);
  import sem_pkg::*;

  // stalled result keeps its payload
  `SEM_ASSERT_NXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result), "result dropped or changed under stall")

  // only interior centers leave the block
  `SEM_ASSERT_IMP(a_interior, result_valid, result.center_column != '0 && result.center_row != '0, "border pixel emitted")

  // one pixel request in flight at a time
  `SEM_ASSERT_NXT(a_one_inflight, pixel_valid && pixel_ready, !pixel_ready, "pixel accepted while busy")

  // reset empties the output register
  `SEM_ASSERT_RST(a_reset_empty, rst, !result_valid, "result valid after reset")

endmodule

bind sobel_edge_magnitude_top sem_checker u_sem_checker (
  .clk          (clk),
  .rst          (rst),
  .pixel_valid  (pixel_valid),
  .pixel_ready  (pixel_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge magnitude - testbench
// Drives raster frames through the pixel port and predicts every interior
// result. Each result is checked in order, field by field. Frame geometry
// is reprogrammed between frames, gray/color mode also within a frame.
// ----------------------------------------------------------------------------
module tb_top;

  import sem_pkg::pixel_t;
  import sem_pkg::result_t;

  // Unused register slot: writes there must change nothing.
  localparam logic [1:0] REG_SPARE = 2'd3;

  localparam int CLK_HALF         = 6;
  localparam int SETTLE_CYCLES    = 40;    // wait after a drain, before register writes
  localparam int HOLD_CYCLES      = 300;   // long result back-pressure
  localparam int WATCHDOG_LIMIT   = 3000;  // cycles with no handshake at all
  localparam int RANDOM_PER_PHASE = 180;
  localparam int MAX_REPORTS      = 40;

  // How a stimulus row is checked.
  typedef enum logic [1:0] {PREDICTED, NO_EDGE, KNOWN_EDGE} row_kind_e;

  typedef struct packed {
    logic [11:0] w;
    logic [11:0] h;
    logic        mode;
    row_kind_e   kind;
    pixel_t      px;
    result_t     res;
  } stim_row_t;

  typedef struct packed {
    row_kind_e kind;
    result_t   res;
  } row_note_t;

  localparam result_t NO_RES = '0;

  // Directed rows, walked in order. Geometry or mode changes between rows
  // trigger a reprogram. NO_EDGE / KNOWN_EDGE rows override the predictor.
  localparam stim_row_t DIRECTED_ROWS [25] = '{
    // reset geometry 640x480, gray: first row never yields a result
    '{12'd640, 12'd480, 1'b0, NO_EDGE, '{8'hFF, 8'h00, 8'h00}, NO_RES},
    '{12'd640, 12'd480, 1'b0, NO_EDGE, '{8'h00, 8'hFF, 8'hFF}, NO_RES},
    '{12'd640, 12'd480, 1'b0, NO_EDGE, '{8'h5A, 8'hA5, 8'h3C}, NO_RES},
    // 2x2 frame is below the 3x3 window: silent
    '{12'd2, 12'd2, 1'b0, NO_EDGE, '{8'hFF, 8'hFF, 8'hFF}, NO_RES},
    '{12'd2, 12'd2, 1'b0, NO_EDGE, '{8'h00, 8'h00, 8'h00}, NO_RES},
    '{12'd2, 12'd2, 1'b0, NO_EDGE, '{8'h00, 8'hFF, 8'h00}, NO_RES},
    '{12'd2, 12'd2, 1'b0, NO_EDGE, '{8'hFF, 8'h00, 8'hFF}, NO_RES},
    // 3x3 gray, dark left / bright right: gx = 4*255, saturates
    '{12'd3, 12'd3, 1'b0, NO_EDGE, '{8'd0,   8'd0, 8'd0}, NO_RES},
    '{12'd3, 12'd3, 1'b0, NO_EDGE, '{8'd128, 8'd0, 8'd0}, NO_RES},
    '{12'd3, 12'd3, 1'b0, NO_EDGE, '{8'd255, 8'd0, 8'd0}, NO_RES},
    '{12'd3, 12'd3, 1'b0, NO_EDGE, '{8'd0,   8'd0, 8'd0}, NO_RES},
    '{12'd3, 12'd3, 1'b0, NO_EDGE, '{8'd128, 8'd0, 8'd0}, NO_RES},
    '{12'd3, 12'd3, 1'b0, NO_EDGE, '{8'd255, 8'd0, 8'd0}, NO_RES},
    '{12'd3, 12'd3, 1'b0, NO_EDGE, '{8'd0,   8'd0, 8'd0}, NO_RES},
    '{12'd3, 12'd3, 1'b0, NO_EDGE, '{8'd128, 8'd0, 8'd0}, NO_RES},
    '{12'd3, 12'd3, 1'b0, KNOWN_EDGE, '{8'd255, 8'd0, 8'd0},
      '{11'd1, 11'd1, 8'd255, 1'b1}},
    // 3x3 color: pure blue right column -> gray 29, gx = 4*29 = 116
    '{12'd3, 12'd3, 1'b1, PREDICTED, '{8'd0,   8'd0, 8'd0},   NO_RES},
    '{12'd3, 12'd3, 1'b1, PREDICTED, '{8'd255, 8'd0, 8'd0},   NO_RES},
    '{12'd3, 12'd3, 1'b1, PREDICTED, '{8'd0,   8'd0, 8'd255}, NO_RES},
    '{12'd3, 12'd3, 1'b1, PREDICTED, '{8'd0,   8'd0, 8'd0},   NO_RES},
    '{12'd3, 12'd3, 1'b1, PREDICTED, '{8'd255, 8'd0, 8'd0},   NO_RES},
    '{12'd3, 12'd3, 1'b1, PREDICTED, '{8'd0,   8'd0, 8'd255}, NO_RES},
    '{12'd3, 12'd3, 1'b1, PREDICTED, '{8'd0,   8'd0, 8'd0},   NO_RES},
    '{12'd3, 12'd3, 1'b1, PREDICTED, '{8'd255, 8'd0, 8'd0},   NO_RES},
    '{12'd3, 12'd3, 1'b1, KNOWN_EDGE, '{8'd0, 8'd0, 8'd255},
      '{11'd1, 11'd1, 8'd116, 1'b1}}
  };

  // Idle mix per phase: sender idle percent, receiver stall percent.
  localparam int SRC_IDLE [4]   = '{0, 63, 0, 38};
  localparam int SINK_STALL [4] = '{0, 0, 63, 38};

  logic                      clk;
  logic                      rst;
  logic                      pixel_valid;
  logic                      pixel_ready;
  pixel_t                    pixel;
  logic                      result_valid;
  logic                      result_ready;
  result_t                   result;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [1:0]                cfg_index;
  logic [sem_pkg::DIM_W-1:0] cfg_data;

  sobel_edge_magnitude_top uut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Gradient predictor: private copy of the line stores, window and
  // raster position, plus the programmed geometry.
  // --------------------------------------------------------------------------
  bit [7:0]    older_line [sem_pkg::MAX_WIDTH];
  bit [7:0]    newer_line [sem_pkg::MAX_WIDTH];
  bit [7:0]    taps [3][3];
  int unsigned col_pos;
  int unsigned row_pos;
  bit [11:0]   width_reg  = 12'd640;
  bit [11:0]   height_reg = 12'd480;
  bit          colour_reg = 1'b0;

  result_t     expected_edges [$];  // magnitudes waiting for the block
  row_note_t   row_notes [$];       // one per offered pixel, in order

  int          failures;
  int          pixels_in;
  int          edges_checked;
  int          reg_writes;
  int          geometry_runs;
  int          src_idle_pct;
  int          sink_stall_pct;
  int          holds_asked;
  int          holds_served;

  // 0 acts as 1, anything above the store depth acts as the depth
  function automatic int unsigned span(input bit [11:0] v, input int unsigned limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  // largest r with r*r <= v, v below 2^16
  function automatic int unsigned floor_root(input int unsigned v);
    int unsigned r;
    int          b;
    r = 0;
    for (b = 7; b >= 0; b--) begin
      if ((r | (1 << b)) * (r | (1 << b)) <= v) r = r | (1 << b);
    end
    return r;
  endfunction

  task automatic raster_step(input pixel_t p, output bit hit, output result_t r);
    int unsigned w, h, c, y, sq, luma;
    int          gx, gy, i;
    bit [7:0]    top, mid;
    w = span(width_reg, sem_pkg::MAX_WIDTH);
    h = span(height_reg, sem_pkg::MAX_HEIGHT);
    c = col_pos;
    y = row_pos;
    if (colour_reg)
      luma = (299 * p.first_channel + 587 * p.second_channel
              + 114 * p.third_channel) / 1000;
    else
      luma = p.first_channel;
    top = older_line[c];
    mid = newer_line[c];
    for (i = 0; i < 3; i++) begin
      taps[i][0] = taps[i][1];
      taps[i][1] = taps[i][2];
    end
    taps[0][2] = top;
    taps[1][2] = mid;
    taps[2][2] = 8'(luma);
    older_line[c] = mid;
    newer_line[c] = 8'(luma);
    hit = (w >= 3 && h >= 3 && c >= 2 && y >= 2);
    r = '0;
    if (hit) begin
      gx = (int'(taps[0][2]) + 2 * int'(taps[1][2]) + int'(taps[2][2]))
         - (int'(taps[0][0]) + 2 * int'(taps[1][0]) + int'(taps[2][0]));
      gy = (int'(taps[2][0]) + 2 * int'(taps[2][1]) + int'(taps[2][2]))
         - (int'(taps[0][0]) + 2 * int'(taps[0][1]) + int'(taps[0][2]));
      sq = gx * gx + gy * gy;
      r.center_column  = 11'(c - 1);
      r.center_row     = 11'(y - 1);
      r.edge_magnitude = (sq >= 65536) ? 8'd255 : 8'(floor_root(sq));
      r.frame_done     = (c == w - 1) && (y == h - 1);
    end
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (y + 1 >= h) ? 0 : y + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      failures++;
      if (failures <= MAX_REPORTS)
        $display("%0t tb_top: %s mismatch, expected %0d, actual %0d",
                 $time, field, want, got);
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: all three handshakes sampled in one block, so register writes,
  // predictions and result checks see one consistent order per edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    row_note_t note;
    bit        hit;
    result_t   r;
    result_t   want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        reg_writes++;
        case (cfg_index)
          sem_pkg::REG_WIDTH: begin
            width_reg = cfg_data;
            col_pos   = 0;
            row_pos   = 0;
          end
          sem_pkg::REG_HEIGHT: begin
            height_reg = cfg_data;
            col_pos    = 0;
            row_pos    = 0;
          end
          sem_pkg::REG_MODE: colour_reg = cfg_data[0];
          default: ;  // spare slot, ignored
        endcase
      end
      if (pixel_valid && pixel_ready) begin
        pixels_in++;
        note = row_notes.pop_front();
        raster_step(pixel, hit, r);
        case (note.kind)
          PREDICTED:  if (hit) expected_edges.push_back(r);
          KNOWN_EDGE: expected_edges.push_back(note.res);
          default: ;  // NO_EDGE: nothing may come out
        endcase
      end
      if (result_valid && result_ready) begin
        if (expected_edges.size() == 0) begin
          failures++;
          if (failures <= MAX_REPORTS)
            $display("%0t tb_top: unexpected result, expected none, actual %0d/%0d/%0d/%0d",
                     $time, result.center_column, result.center_row,
                     result.edge_magnitude, result.frame_done);
        end else begin
          want = expected_edges.pop_front();
          edges_checked++;
          compare_field("center_column", want.center_column, result.center_column);
          compare_field("center_row", want.center_row, result.center_row);
          compare_field("edge_magnitude", want.edge_magnitude, result.edge_magnitude);
          compare_field("frame_done", want.frame_done, result.frame_done);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result sink: random stalls per phase; a long hold-off on request, counted
  // here so the sender keeps pushing and the block backs up into its input.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    result_ready = 1'b0;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (holds_served != holds_asked) begin
        holds_served++;
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        result_ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Watchdog: any handshake resets the count of quiet cycles.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((pixel_valid && pixel_ready) || (result_valid && result_ready)
          || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t tb_top: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("tb_top: done, errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Pixel source helpers
  // --------------------------------------------------------------------------
  // one channel byte in a given texture: full random, soft ramp, hard
  // black/white, near-black noise
  function automatic bit [7:0] shade(input int style, input int base);
    case (style)
      0:       return 8'($urandom_range(255));
      1:       return 8'(base + $urandom_range(7));
      2:       return $urandom_range(1) ? 8'hFF : 8'h00;
      default: return 8'($urandom_range(3));
    endcase
  endfunction

  function automatic pixel_t texel(input int style, input int base);
    pixel_t p;
    p.first_channel  = shade(style, base);
    p.second_channel = shade(style, base);
    p.third_channel  = shade(style, base);
    return p;
  endfunction

  // Offer one request; valid stays up across back-to-back requests.
  task automatic offer_pixel(input pixel_t p, input row_kind_e kind, input result_t res);
    row_note_t n;
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      pixel_valid <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
    n.kind = kind;
    n.res  = res;
    row_notes.push_back(n);
    pixel_valid <= 1'b1;
    pixel       <= p;
    do @(posedge clk); while (!pixel_ready);
  endtask

  // Sender stops until every outstanding magnitude has come back.
  task automatic wait_drained();
    pixel_valid <= 1'b0;
    do @(posedge clk); while (expected_edges.size() != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [11:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Drain, let a trailing border pixel finish, then rewrite all registers.
  task automatic program_geometry(input logic [11:0] w, input logic [11:0] h,
                                  input bit mode);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(sem_pkg::REG_WIDTH, w);
    write_reg(sem_pkg::REG_HEIGHT, h);
    write_reg(sem_pkg::REG_MODE, 12'(mode));
    write_reg(REG_SPARE, 12'($urandom_range(4095)));
    cfg_valid <= 1'b0;
    geometry_runs++;
  endtask

  task automatic send_frame_pixels(input int count, input int style, input int base);
    repeat (count) offer_pixel(texel(style, base), PREDICTED, NO_RES);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [11:0] cur_w, cur_h, w, h;
    bit          cur_mode, mode;
    int          ph, sent, sel, area, n;

    rst            = 1'b1;
    pixel_valid    = 1'b0;
    pixel          = '0;
    cfg_valid      = 1'b0;
    cfg_index      = sem_pkg::REG_WIDTH;
    cfg_data       = '0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    holds_asked    = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed rows; the first ones run on the reset geometry.
    cur_w    = 12'd640;
    cur_h    = 12'd480;
    cur_mode = 1'b0;
    foreach (DIRECTED_ROWS[i]) begin
      if (DIRECTED_ROWS[i].w != cur_w || DIRECTED_ROWS[i].h != cur_h
          || DIRECTED_ROWS[i].mode != cur_mode) begin
        cur_w    = DIRECTED_ROWS[i].w;
        cur_h    = DIRECTED_ROWS[i].h;
        cur_mode = DIRECTED_ROWS[i].mode;
        program_geometry(cur_w, cur_h, cur_mode);
      end
      offer_pixel(DIRECTED_ROWS[i].px, DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].res);
    end

    for (ph = 0; ph < 4; ph++) begin
      src_idle_pct   = SRC_IDLE[ph];
      sink_stall_pct = SINK_STALL[ph];

      if (ph == 0) begin
        // Back-pressure: sink holds off while a full 8x8 frame is offered.
        program_geometry(12'd8, 12'd8, 1'b0);
        holds_asked++;
        send_frame_pixels(64, 0, 0);
      end

      sent = 0;
      while (sent < RANDOM_PER_PHASE) begin
        // Mostly small whole frames, some wide rows, some degenerate sizes.
        sel = $urandom_range(99);
        if (sel < 75) begin
          w = 12'($urandom_range(3, 16));
          h = 12'($urandom_range(3, 8));
        end else if (sel < 88) begin
          w = 12'($urandom_range(17, 80));
          h = 12'($urandom_range(3, 5));
        end else if (sel < 94) begin
          w = 12'($urandom_range(0, 2));
          h = 12'($urandom_range(0, 6));
        end else begin
          w = 12'($urandom_range(3, 10));
          h = 12'($urandom_range(0, 2));
        end
        mode = $urandom_range(1);
        program_geometry(w, h, mode);
        area = span(w, sem_pkg::MAX_WIDTH) * span(h, sem_pkg::MAX_HEIGHT);

        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(7) == 0) wait_drained();
          send_frame_pixels(area, $urandom_range(3), $urandom_range(248));
          sent += area;
        end

        // Mode flip without a geometry write: the frame carries on.
        if ($urandom_range(99) < 15) begin
          wait_drained();
          repeat (SETTLE_CYCLES) @(posedge clk);
          write_reg(sem_pkg::REG_MODE, 12'(!mode));
          cfg_valid <= 1'b0;
          n = $urandom_range(1, area);
          send_frame_pixels(n, $urandom_range(3), $urandom_range(248));
          sent += n;
        end

        // Truncated frame; the next geometry write restarts the raster.
        if ($urandom_range(99) < 15) begin
          n = $urandom_range(1, area);
          send_frame_pixels(n, $urandom_range(3), $urandom_range(248));
          sent += n;
        end
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_edges.size() != 0) begin
      failures++;
      $display("%0t tb_top: %0d magnitudes never arrived", $time, expected_edges.size());
    end

    $display("tb_top: %0d pixels over %0d geometry settings, %0d register writes",
             pixels_in, geometry_runs, reg_writes);
    $display("tb_top: %0d edge magnitudes compared, %0d failures",
             edges_checked, failures);
    if (failures == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
